// ===== design/double_hash_key_set_assert.svh =====
// assertion macros for the key set checker
`ifndef DOUBLE_HASH_KEY_SET_ASSERT_SVH
`define DOUBLE_HASH_KEY_SET_ASSERT_SVH

// same-cycle implication
`define DHKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DHKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dhks_pkg.sv =====
package dhks_pkg;

	localparam int DEF_TABLE_SIZE = 512;
	localparam int DEF_KEY_BYTES  = 8;
	localparam int KEY_W          = 64;
	localparam int LEN_W          = 4;
	localparam int SLOT_W         = 9;
	localparam int HASH_W         = 32;
	localparam int HASH_MUL1      = 37;
	localparam int HASH_MUL2      = 31;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MODA,
		ST_MODB,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} hash_ctl_t;

endpackage

// ===== design/dhks_ram.sv =====
module dhks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/dhks_hash.sv =====
module dhks_hash
	import dhks_pkg::*;
#(
	parameter int KEY_BYTES = DEF_KEY_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hash_ctl_t              ctl,
	input  logic [KEY_BYTES*8-1:0] key_in,
	output logic [HASH_W-1:0]      h1,
	output logic [HASH_W-1:0]      h2
);

	localparam int KW = KEY_BYTES * 8;

	logic [KW-1:0]     sh_q;
	logic [HASH_W-1:0] h1_q;
	logic [HASH_W-1:0] h2_q;
	logic [HASH_W-1:0] byte_w;

	// shift right by one byte per step, byte 0 first
	assign byte_w = HASH_W'(sh_q[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q <= '0;
			h2_q <= '0;
		end else if (ctl.load) begin
			h1_q <= '0;
			h2_q <= '0;
		end else if (ctl.step) begin
			h1_q <= h1_q * HASH_W'(HASH_MUL1) + byte_w;
			h2_q <= h2_q * HASH_W'(HASH_MUL2) + byte_w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q <= key_in;
		end else if (ctl.step) begin
			sh_q <= sh_q >> 8;
		end
	end

	assign h1 = h1_q;
	assign h2 = h2_q;

endmodule

// ===== design/dhks_mod.sv =====
module dhks_mod
	import dhks_pkg::*;
#(
	parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [HASH_W-1:0]             x,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] r
);

	localparam int SW = $clog2(TABLE_SIZE);

	logic          done_q;
	logic [SW-1:0] r_q;

	if ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0) begin : g_pow2
		// low bits give the remainder directly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				r_q <= x[SW-1:0];
			end
		end
	end else begin : g_recip
		localparam int             M_W = HASH_W + 1;
		localparam int             P_W = HASH_W + M_W;
		localparam int             SH  = HASH_W + SW;
		localparam logic [63:0]    M64 = (64'd1 << SH) / 64'(TABLE_SIZE);
		localparam logic [M_W-1:0] M_C = M_W'(M64);
		localparam logic [SW:0]    N_C = (SW+1)'(TABLE_SIZE);

		logic [P_W-1:0] prod;
		logic [SW:0]    qn;
		logic [SW:0]    q_s1;
		logic [SW:0]    x_s1;
		logic           v_s1;
		logic [SW:0]    rem_s2;
		logic           v_s2;

		// quotient estimate by reciprocal is exact or one low, low bits suffice
		assign prod = {M_W'(0), x} * {HASH_W'(0), M_C};
		assign qn   = (SW+1)'(q_s1 * N_C);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1   <= 1'b0;
				v_s2   <= 1'b0;
				done_q <= 1'b0;
			end else begin
				v_s1   <= start;
				v_s2   <= v_s1;
				done_q <= v_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				q_s1 <= prod[SH +: SW+1];
				x_s1 <= x[SW:0];
			end
			if (v_s1) begin
				rem_s2 <= x_s1 - qn;
			end
			if (v_s2) begin
				r_q <= (rem_s2 >= N_C) ? SW'(rem_s2 - N_C) : SW'(rem_s2);
			end
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

// ===== design/double_hash_key_set.sv =====
// a request hashes min(key_len, KEY_BYTES) key bytes, then reduces h1 and h2 (made odd) modulo TABLE_SIZE,
// by the low bits for a power-of-two TABLE_SIZE, else by reciprocal, then probes slots in turn
// one request at a time, accepted only while idle; each probe has a read and a compare state
// done is a one-cycle strobe and cannot be held off; busy drops in the same cycle
// reset: the valid marks are swept to zero with busy high
module double_hash_key_set
	import dhks_pkg::*;
#(
	parameter int TABLE_SIZE = DEF_TABLE_SIZE,
	parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [KEY_W-1:0]  key,
	input  logic [LEN_W-1:0]  key_len,
	output logic              done,
	output logic              present,
	output logic              inserted,
	output logic              full_res,
	output logic [SLOT_W-1:0] slot
);

	localparam int SW = $clog2(TABLE_SIZE);
	localparam int KW = KEY_BYTES * 8;
	localparam logic [SW:0]      N_C    = (SW+1)'(TABLE_SIZE);
	localparam logic [63:0]      WRAP64 = (64'd1 << 32) % 64'(TABLE_SIZE);
	localparam logic [SW:0]      W_C    = (SW+1)'(WRAP64);
	localparam logic [SW-1:0]    LAST_C = SW'(TABLE_SIZE - 1);
	localparam logic [LEN_W-1:0] KB_C   = LEN_W'(KEY_BYTES);

	state_t state_q, state_n;

	logic [SW-1:0]     i_q;
	logic [SW-1:0]     s_q;
	logic [SW-1:0]     bm_q;
	logic [SW-1:0]     am_q;
	logic [HASH_W-1:0] p_q;
	logic [HASH_W-1:0] b_q;
	logic [KW-1:0]     key_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              kind_q;

	logic              done_q;
	logic              present_q;
	logic              inserted_q;
	logic              full_q;
	logic [SLOT_W-1:0] slot_q;

	logic [LEN_W-1:0]  len_c;
	logic [KW-1:0]     key_m;
	logic              accept;

	hash_ctl_t         hash_ctl;
	logic [HASH_W-1:0] h1;
	logic [HASH_W-1:0] h2;
	logic [HASH_W-1:0] h2_odd;

	logic              mod_start;
	logic [HASH_W-1:0] mod_x;
	logic              mod_done;
	logic [SW-1:0]     mod_r;

	logic              vld_we;
	logic [SW-1:0]     vld_waddr;
	logic              vld_wdata;
	logic              vld_rd;
	logic              key_we;
	logic [KW+LEN_W-1:0] key_rd;

	logic              hit;
	logic              empty;
	logic              last;
	logic              stop;

	logic [HASH_W:0]   p_sum;
	logic [SW:0]       t_sum;
	logic [SW:0]       t_red;
	logic [SW:0]       u_red;
	logic [SW-1:0]     s_next;

	// clamp length, clear bytes past it
	assign len_c = (key_len > KB_C) ? KB_C : key_len;

	always_comb begin
		for (int j = 0; j < KEY_BYTES; j++) begin
			key_m[8*j +: 8] = (LEN_W'(j) < len_c) ? key[8*j +: 8] : 8'd0;
		end
	end

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign h2_odd = h2 | HASH_W'(1);

	dhks_hash #(
		.KEY_BYTES(KEY_BYTES)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (hash_ctl),
		.key_in(key_m),
		.h1    (h1),
		.h2    (h2)
	);

	dhks_mod #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.x     (mod_x),
		.done  (mod_done),
		.r     (mod_r)
	);

	dhks_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_SIZE)
	) u_vld_ram (
		.clk  (clk),
		.we   (vld_we),
		.waddr(vld_waddr),
		.wdata(vld_wdata),
		.raddr(s_q),
		.rdata(vld_rd)
	);

	dhks_ram #(
		.WIDTH(KW + LEN_W),
		.DEPTH(TABLE_SIZE)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(s_q),
		.wdata({len_q, key_q}),
		.raddr(s_q),
		.rdata(key_rd)
	);

	// probe compare
	assign hit   = vld_rd && (key_rd[KW +: LEN_W] == len_q) && (key_rd[KW-1:0] == key_q);
	assign empty = !vld_rd;
	assign last  = (i_q == LAST_C);
	assign stop  = hit || empty || last;

	// next probe slot, tracking the 32-bit wrap of h1 + i*h2
	assign p_sum = {1'b0, p_q} + {1'b0, b_q};
	assign t_sum = {1'b0, s_q} + {1'b0, bm_q};
	assign t_red = (t_sum >= N_C) ? t_sum - N_C : t_sum;

	always_comb begin
		if (p_sum[HASH_W]) begin
			u_red = (t_red >= W_C) ? t_red - W_C : t_red + N_C - W_C;
		end else begin
			u_red = t_red;
		end
	end

	assign s_next = u_red[SW-1:0];

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_n = ST_HASH;
				end
			end
			ST_HASH: begin
				if (cnt_q == '0) begin
					state_n = ST_MODA;
				end
			end
			ST_MODA: begin
				if (mod_done) begin
					state_n = ST_MODB;
				end
			end
			ST_MODB: begin
				if (mod_done) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				state_n = stop ? ST_IDLE : ST_READ;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		hash_ctl  = '0;
		mod_start = 1'b0;
		mod_x     = h1;
		vld_we    = 1'b0;
		vld_waddr = s_q;
		vld_wdata = 1'b0;
		key_we    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				vld_we    = 1'b1;
				vld_waddr = i_q;
			end
			ST_IDLE: begin
				hash_ctl.load = start;
			end
			ST_HASH: begin
				hash_ctl.step = (cnt_q != '0);
				mod_start     = (cnt_q == '0);
			end
			ST_MODA: begin
				mod_start = mod_done;
				mod_x     = h2_odd;
			end
			ST_MODB, ST_READ: begin
			end
			ST_CHECK: begin
				vld_we    = empty && kind_q;
				vld_wdata = 1'b1;
				key_we    = empty && kind_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			i_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == ST_CHECK) && stop;
			if (accept) begin
				cnt_q <= len_c;
			end else if (state_q == ST_HASH && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == ST_CLEAR) begin
				i_q <= last ? '0 : i_q + 1'b1;
			end else if (state_q == ST_MODB) begin
				i_q <= '0;
			end else if (state_q == ST_CHECK && !stop) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_m;
			len_q  <= len_c;
			kind_q <= kind;
		end
		if (state_q == ST_MODA && mod_done) begin
			am_q <= mod_r;
		end
		if (state_q == ST_MODB && mod_done) begin
			bm_q <= mod_r;
			s_q  <= am_q;
			p_q  <= h1;
			b_q  <= h2_odd;
		end
		if (state_q == ST_CHECK) begin
			if (stop) begin
				present_q  <= hit;
				inserted_q <= empty && kind_q;
				full_q     <= !hit && !empty;
				slot_q     <= SLOT_W'(s_q);
			end else begin
				s_q <= s_next;
				p_q <= p_sum[HASH_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign present  = present_q;
	assign inserted = inserted_q;
	assign full_res = full_q;
	assign slot     = slot_q;

endmodule

// ===== design/dhks_checker.sv =====
`include "double_hash_key_set_assert.svh"

module dhks_checker
	import dhks_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              present,
	input logic              inserted,
	input logic              full_res,
	input logic [SLOT_W-1:0] slot
);

	`DHKS_ASSERT_NOW(a_flags_excl, done, !(present && inserted) && !(full_res && (present || inserted)), "result flags conflict")
	`DHKS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted without busy")
	`DHKS_ASSERT_NOW(a_done_idle, done, !busy, "done while still busy")
	`DHKS_ASSERT_NOW(a_done_after_work, done, $past(busy), "done without a request in flight")

endmodule

bind double_hash_key_set dhks_checker u_dhks_checker (.*);

// ===== bench/tb_double_hash_key_set.sv =====
`timescale 1ns / 1ps

module tb_double_hash_key_set;
	import dhks_pkg::*;

	localparam int  TBL          = DEF_TABLE_SIZE;
	localparam bit  KIND_QUERY   = 1'b0;
	localparam bit  KIND_INSERT  = 1'b1;
	localparam int  N_DIRECTED   = 23;
	localparam int  N_MIXED      = 800;
	localparam int  N_FULL       = 250;

	typedef struct packed {
		bit              present;
		bit              inserted;
		bit              full;
		bit [SLOT_W-1:0] slot;
	} lookup_res_t;

	typedef struct {
		bit          op;
		bit [63:0]   k;
		bit [3:0]    n;
		bit          chk;
		lookup_res_t res;
	} directed_row_t;

	typedef struct {
		bit [63:0] k;
		bit [3:0]  n;
	} key_item_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              kind;
	logic [KEY_W-1:0]  key;
	logic [LEN_W-1:0]  key_len;
	logic              done;
	logic              present;
	logic              inserted;
	logic              full_res;
	logic [SLOT_W-1:0] slot;

	double_hash_key_set i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.kind    (kind),
		.key     (key),
		.key_len (key_len),
		.done    (done),
		.present (present),
		.inserted(inserted),
		.full_res(full_res),
		.slot    (slot)
	);

	// mirror of the set contents
	bit [63:0]     set_keys [TBL];
	bit [3:0]      set_lens [TBL];
	bit            set_used [TBL];
	int            used_slots;

	lookup_res_t   exp_lookups[$];
	key_item_t     key_pool[$];
	directed_row_t directed_rows [N_DIRECTED];
	int            error_count;
	int            sent_count;
	int            idle_pct;
	int            idle_pcts [4] = '{0, 81, 0, 12};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#40_000_000;
		$display("tb_double_hash_key_set: done, errors");
		$finish;
	end

	function automatic bit [63:0] len_mask(input bit [3:0] n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic lookup_res_t lookup_key(input bit op, input bit [63:0] raw,
		input bit [3:0] raw_len);
		bit [3:0]        n;
		bit [63:0]       k;
		bit [31:0]       h1;
		bit [31:0]       h2;
		bit [31:0]       pos;
		bit [SLOT_W-1:0] s;
		bit              hit;
		bit              empty;
		int              j;
		int              i;
		lookup_res_t     r;
		n = (raw_len > DEF_KEY_BYTES) ? 4'(DEF_KEY_BYTES) : raw_len;
		k = raw & len_mask(n);
		h1 = 0;
		h2 = 0;
		for (j = 0; j < n; j++) begin
			h1 = h1 * HASH_MUL1 + k[8*j +: 8];
			h2 = h2 * HASH_MUL2 + k[8*j +: 8];
		end
		if (!h2[0])
			h2 = h2 + 1;
		hit = 1'b0;
		empty = 1'b0;
		s = '0;
		for (i = 0; i < TBL; i++) begin
			pos = h1 + 32'(i) * h2;
			s = SLOT_W'(pos % TBL);
			if (!set_used[s]) begin
				empty = 1'b1;
				break;
			end
			if (set_lens[s] == n && set_keys[s] == k) begin
				hit = 1'b1;
				break;
			end
		end
		r.present = hit;
		r.inserted = 1'b0;
		r.full = !hit && !empty;
		r.slot = s;
		if (op == KIND_INSERT && empty) begin
			set_keys[s] = k;
			set_lens[s] = n;
			set_used[s] = 1'b1;
			used_slots++;
			r.inserted = 1'b1;
		end
		return r;
	endfunction

	task automatic issue_request(input bit op, input bit [63:0] k, input bit [3:0] n,
		input bit chk, input lookup_res_t typed);
		lookup_res_t r;
		key_item_t   item;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		key <= k;
		key_len <= n;
		do @(posedge clk); while (busy !== 1'b0);
		r = lookup_key(op, k, n);
		exp_lookups.push_back(chk ? typed : r);
		item.k = k & len_mask(n);
		item.n = n;
		if (key_pool.size() < TBL)
			key_pool.push_back(item);
		else
			key_pool[$urandom_range(TBL - 1)] = item;
		sent_count++;
		idle_pct = idle_pcts[(sent_count / 100) % 4];
	endtask

	// reuse_pct: share of keys drawn from earlier requests, lo: shortest fresh key
	task automatic random_request(input int reuse_pct, input int insert_pct, input int lo);
		bit [63:0] k;
		bit [3:0]  n;
		bit        op;
		key_item_t pick;
		if (key_pool.size() != 0 && $urandom_range(99) < reuse_pct) begin
			pick = key_pool[$urandom_range(key_pool.size() - 1)];
			n = pick.n;
			if (n >= 8 && $urandom_range(1))
				n = 4'($urandom_range(15, 8));
			k = pick.k | ({$urandom, $urandom} & ~len_mask(n));
		end else begin
			if (lo == 0 && $urandom_range(99) < 15)
				n = 4'($urandom_range(2));
			else
				n = 4'($urandom_range(15, lo));
			k = {$urandom, $urandom};
		end
		op = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_QUERY;
		issue_request(op, k, n, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		lookup_res_t want;
		if (arst_n && done === 1'b1) begin
			if (exp_lookups.size() == 0) begin
				error_count++;
				$display("%t unexpected result: present %b inserted %b full %b slot %0d",
					$time, present, inserted, full_res, slot);
			end else begin
				want = exp_lookups.pop_front();
				if ({present, inserted, full_res, slot} !== want) begin
					error_count++;
					$display("%t mismatch: expected present %b inserted %b full %b slot %0d, got present %b inserted %b full %b slot %0d",
						$time, want.present, want.inserted, want.full, want.slot,
						present, inserted, full_res, slot);
				end
			end
		end
	end

	initial begin
		start <= 1'b0;
		kind <= KIND_QUERY;
		key <= '0;
		key_len <= '0;
		idle_pct = 0;
		directed_rows = '{
			'{KIND_QUERY,  64'h0,                   4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 9'd0}},
			'{KIND_INSERT, 64'h0,                   4'd0,  1'b1, '{1'b0, 1'b1, 1'b0, 9'd0}},
			'{KIND_INSERT, 64'h0,                   4'd0,  1'b1, '{1'b1, 1'b0, 1'b0, 9'd0}},
			'{KIND_QUERY,  64'hffff_ffff_ffff_ffff, 4'd0,  1'b1, '{1'b1, 1'b0, 1'b0, 9'd0}},
			'{KIND_QUERY,  64'h0,                   4'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 9'd1}},
			'{KIND_INSERT, 64'hffff_ffff_ffff_ff00, 4'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 9'd1}},
			'{KIND_QUERY,  64'hffff_ffff_ffff_ffff, 4'd8,  1'b0, '0},
			'{KIND_INSERT, 64'hffff_ffff_ffff_ffff, 4'd8,  1'b0, '0},
			'{KIND_QUERY,  64'hffff_ffff_ffff_ffff, 4'd15, 1'b0, '0},
			'{KIND_INSERT, 64'hffff_ffff_ffff_ffff, 4'd9,  1'b0, '0},
			'{KIND_INSERT, 64'h0,                   4'd8,  1'b0, '0},
			'{KIND_QUERY,  64'h0,                   4'd4,  1'b0, '0},
			'{KIND_INSERT, 64'h0000_0000_0041_0041, 4'd4,  1'b0, '0},
			'{KIND_QUERY,  64'hffff_ffff_0041_0041, 4'd4,  1'b0, '0},
			'{KIND_INSERT, 64'h8000_0000_0000_0000, 4'd8,  1'b0, '0},
			'{KIND_QUERY,  64'h8000_0000_0000_0000, 4'd7,  1'b0, '0},
			'{KIND_INSERT, 64'h0123_4567_89ab_cdef, 4'd15, 1'b0, '0},
			'{KIND_QUERY,  64'h0123_4567_89ab_cdef, 4'd8,  1'b0, '0},
			'{KIND_INSERT, 64'h0000_0000_0000_0001, 4'd2,  1'b0, '0},
			'{KIND_INSERT, 64'h0000_0000_0000_2500, 4'd2,  1'b0, '0},
			'{KIND_QUERY,  64'h5a5a_5a5a_5a5a_2500, 4'd2,  1'b0, '0},
			'{KIND_QUERY,  64'h0000_0000_0000_2501, 4'd2,  1'b0, '0},
			'{KIND_INSERT, 64'h0000_0000_0000_007f, 4'd1,  1'b0, '0}
		};
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int r = 0; r < N_DIRECTED; r++)
			issue_request(directed_rows[r].op, directed_rows[r].k, directed_rows[r].n,
				directed_rows[r].chk, directed_rows[r].res);
		repeat (N_MIXED) random_request(45, 50, 0);
		// fill every slot, drawing mostly fresh keys
		while (used_slots < TBL)
			random_request(15, 85, 3);
		repeat (N_FULL) random_request(40, 50, 0);
		start <= 1'b0;
		while (exp_lookups.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (error_count == 0)
			$display("tb_double_hash_key_set: done, clean");
		else
			$display("tb_double_hash_key_set: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/dhks_pkg.sv
design/dhks_ram.sv
design/dhks_hash.sv
design/dhks_mod.sv
design/double_hash_key_set.sv
design/dhks_checker.sv
bench/tb_double_hash_key_set.sv
